### hw/rtl/riscv_instruction_decoder_top_assert.svh
// ============================================================================
// RISC-V decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ============================================================================
`ifndef RISCV_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RISCV_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Antecedent holds now, consequent holds in the same cycle.
`define RVID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds now, consequent holds after the delay given in dly.
`define RVID_ASSERT_LATER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### hw/rtl/rvid_pkg.sv
// ============================================================================
// rvid_pkg
// Codes, opcodes and field helpers for the RV64IM instruction decoder.
// ============================================================================
package rvid_pkg;

    localparam int LATENCY = 3;

    typedef enum logic [3:0] {
        KIND_NOP        = 4'd0,
        KIND_ERROR      = 4'd1,
        KIND_ALU_REG    = 4'd2,
        KIND_ALU_IMM    = 4'd3,
        KIND_LOAD       = 4'd4,
        KIND_STORE      = 4'd5,
        KIND_BRANCH     = 4'd6,
        KIND_LOAD_CONST = 4'd7,
        KIND_JUMP       = 4'd8,
        KIND_CALL       = 4'd9,
        KIND_JUMP_REG   = 4'd10,
        KIND_SYSCALL    = 4'd11
    } kind_t;

    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SHL  = 4'd2,
        ALU_SHR  = 4'd3,
        ALU_SAR  = 4'd4,
        ALU_SLT  = 4'd5,
        ALU_SLTU = 4'd6,
        ALU_XOR  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9,
        ALU_MUL  = 4'd10,
        ALU_DIV  = 4'd11,
        ALU_DIVU = 4'd12,
        ALU_MOD  = 4'd13,
        ALU_NONE = 4'd14
    } alu_op_t;

    typedef enum logic [2:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LT  = 3'd2,
        COND_GE  = 3'd3,
        COND_LTU = 3'd4,
        COND_GEU = 3'd5
    } cond_t;

    localparam logic [6:0] OPC_OP        = 7'h33;
    localparam logic [6:0] OPC_OP_32     = 7'h3B;
    localparam logic [6:0] OPC_OP_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_LOAD      = 7'h03;
    localparam logic [6:0] OPC_STORE     = 7'h23;
    localparam logic [6:0] OPC_BRANCH    = 7'h63;
    localparam logic [6:0] OPC_LUI       = 7'h37;
    localparam logic [6:0] OPC_AUIPC     = 7'h17;
    localparam logic [6:0] OPC_JAL       = 7'h6F;
    localparam logic [6:0] OPC_JALR      = 7'h67;
    localparam logic [6:0] OPC_SYSTEM    = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MEXT = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [4:0] REG_SYSCALL_NUM = 5'd17;

    function automatic alu_op_t reg_op(input logic [2:0] f3);
        alu_op_t r;
        case (f3)
            3'd0:    r = ALU_ADD;
            3'd1:    r = ALU_SHL;
            3'd2:    r = ALU_SLT;
            3'd3:    r = ALU_SLTU;
            3'd4:    r = ALU_XOR;
            3'd5:    r = ALU_SHR;
            3'd6:    r = ALU_OR;
            default: r = ALU_AND;
        endcase
        return r;
    endfunction

    function automatic alu_op_t m_op(input logic [2:0] f3);
        alu_op_t r;
        case (f3)
            3'd0:    r = ALU_MUL;
            3'd4:    r = ALU_DIV;
            3'd5:    r = ALU_DIVU;
            3'd6:    r = ALU_MOD;
            default: r = ALU_NONE;
        endcase
        return r;
    endfunction

    function automatic cond_t br_cond(input logic [2:0] f3);
        cond_t r;
        case (f3)
            3'd1:    r = COND_NE;
            3'd4:    r = COND_LT;
            3'd5:    r = COND_GE;
            3'd6:    r = COND_LTU;
            3'd7:    r = COND_GEU;
            default: r = COND_EQ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] imm_i(input logic [31:0] x);
        return {{20{x[31]}}, x[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] x);
        return {{20{x[31]}}, x[31:25], x[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] x);
        return {{20{x[31]}}, x[7], x[30:25], x[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_u(input logic [31:0] x);
        return {x[31:12], 12'h000};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] x);
        return {{12{x[31]}}, x[19:12], x[20], x[30:21], 1'b0};
    endfunction

endpackage

### hw/rtl/riscv_instruction_decoder_top.sv
// ============================================================================
// riscv_instruction_decoder_top
// Three-stage RV64IM decoder: capture, field decode, constant add and output.
// ============================================================================
// done is high once a request has passed the capture, decode and output registers.
// Throughput: one request per cycle; busy is never raised.
// Stage 3 holds the 64-bit add that forms the LUI, AUIPC and link constants.
// Reset clears the stage valid bits only; payload registers are not reset.
module riscv_instruction_decoder_top
    import rvid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instruction,
    input  logic [63:0] pc,
    input  logic [2:0]  bytes_available,
    output logic        done,
    output logic [3:0]  kind,
    output logic [3:0]  alu_op,
    output logic [2:0]  branch_cond,
    output logic [4:0]  src_a,
    output logic [4:0]  src_b,
    output logic [4:0]  dest,
    output logic        dest_write,
    output logic signed [31:0] immediate,
    output logic [63:0] const_value,
    output logic [1:0]  mem_size,
    output logic        mem_signed
);

    `include "riscv_instruction_decoder_top_assert.svh"

    // ---------------- stage 1: capture ----------------
    logic        s1_valid_reg;
    logic [31:0] s1_insn_reg;
    logic [63:0] s1_pc_reg;
    logic        s1_avail_reg;

    // ---------------- stage 2: decoded fields ----------------
    logic        s2_valid_reg;
    kind_t       s2_kind_reg,   s2_kind_next;
    alu_op_t     s2_alu_reg,    s2_alu_next;
    cond_t       s2_cond_reg,   s2_cond_next;
    logic [4:0]  s2_sa_reg,     s2_sa_next;
    logic [4:0]  s2_sb_reg,     s2_sb_next;
    logic [4:0]  s2_dst_reg,    s2_dst_next;
    logic        s2_wr_reg,     s2_wr_next;
    logic [31:0] s2_imm_reg,    s2_imm_next;
    logic [1:0]  s2_msize_reg,  s2_msize_next;
    logic        s2_msig_reg,   s2_msig_next;
    logic [63:0] s2_cbase_reg,  s2_cbase_next;
    logic [63:0] s2_cadd_reg,   s2_cadd_next;

    // ---------------- stage 3: outputs ----------------
    logic        s3_valid_reg;
    kind_t       s3_kind_reg;
    alu_op_t     s3_alu_reg;
    cond_t       s3_cond_reg;
    logic [4:0]  s3_sa_reg;
    logic [4:0]  s3_sb_reg;
    logic [4:0]  s3_dst_reg;
    logic        s3_wr_reg;
    logic [31:0] s3_imm_reg;
    logic [63:0] s3_cval_reg,   s3_cval_next;
    logic [1:0]  s3_msize_reg;
    logic        s3_msig_reg;

    logic        accept;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        writes;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_insn_reg  <= instruction;
            s1_pc_reg    <= pc;
            s1_avail_reg <= bytes_available[2];   // 4 or more bytes
        end
    end

    assign opc = s1_insn_reg[6:0];
    assign f3  = s1_insn_reg[14:12];
    assign f7  = s1_insn_reg[31:25];
    assign rd  = s1_insn_reg[11:7];
    assign rs1 = s1_insn_reg[19:15];
    assign rs2 = s1_insn_reg[24:20];

    always_comb
    begin
        s2_kind_next  = KIND_NOP;
        s2_alu_next   = ALU_NONE;
        s2_cond_next  = COND_EQ;
        s2_sa_next    = '0;
        s2_sb_next    = '0;
        s2_imm_next   = '0;
        s2_msize_next = '0;
        s2_msig_next  = 1'b0;
        s2_cbase_next = '0;
        s2_cadd_next  = '0;
        writes        = 1'b0;

        if (!s1_avail_reg)
        begin
            s2_kind_next = KIND_ERROR;
        end
        else if (opc inside {OPC_OP, OPC_OP_32})
        begin
            s2_kind_next = KIND_ALU_REG;
            s2_sa_next   = rs1;
            s2_sb_next   = rs2;
            writes       = 1'b1;
            if (f7 == F7_MEXT)
            begin
                s2_alu_next = m_op(f3);
            end
            else if (f7 == F7_ALT && f3 == 3'd0)
            begin
                s2_alu_next = ALU_SUB;
            end
            else if (f7 == F7_ALT && f3 == 3'd5)
            begin
                s2_alu_next = ALU_SAR;
            end
            else
            begin
                s2_alu_next = reg_op(f3);
            end
        end
        else if (opc inside {OPC_OP_IMM, OPC_OP_IMM_32})
        begin
            s2_kind_next = KIND_ALU_IMM;
            s2_sa_next   = rs1;
            writes       = 1'b1;
            s2_alu_next  = reg_op(f3);
            if (f3 == 3'd1 || f3 == 3'd5)
            begin
                s2_imm_next = {26'd0, s1_insn_reg[25:20]};
            end
            else
            begin
                s2_imm_next = imm_i(s1_insn_reg);
            end
            if (f3 == 3'd5 && s1_insn_reg[30])
            begin
                s2_alu_next = ALU_SAR;
            end
        end
        else if (opc == OPC_LOAD)
        begin
            s2_kind_next  = KIND_LOAD;
            s2_sa_next    = rs1;
            writes        = 1'b1;
            s2_imm_next   = imm_i(s1_insn_reg);
            s2_msize_next = f3[1:0];
            s2_msig_next  = (f3 < 3'd3);
        end
        else if (opc == OPC_STORE)
        begin
            s2_kind_next  = KIND_STORE;
            s2_sa_next    = rs1;
            s2_sb_next    = rs2;
            s2_imm_next   = imm_s(s1_insn_reg);
            s2_msize_next = f3[2] ? 2'd3 : f3[1:0];
        end
        else if (opc == OPC_BRANCH)
        begin
            // funct3 2 and 3 are reserved: stays a nop
            if (f3 != 3'd2 && f3 != 3'd3)
            begin
                s2_kind_next = KIND_BRANCH;
                s2_sa_next   = rs1;
                s2_sb_next   = rs2;
                s2_cond_next = br_cond(f3);
                s2_imm_next  = imm_b(s1_insn_reg);
            end
        end
        else if (opc == OPC_LUI)
        begin
            s2_kind_next = KIND_LOAD_CONST;
            writes       = 1'b1;
            s2_imm_next  = imm_u(s1_insn_reg);
            s2_cadd_next = {{32{s1_insn_reg[31]}}, imm_u(s1_insn_reg)};
        end
        else if (opc == OPC_AUIPC)
        begin
            s2_kind_next  = KIND_LOAD_CONST;
            writes        = 1'b1;
            s2_imm_next   = imm_u(s1_insn_reg);
            s2_cbase_next = s1_pc_reg;
            s2_cadd_next  = {{32{s1_insn_reg[31]}}, imm_u(s1_insn_reg)};
        end
        else if (opc == OPC_JAL)
        begin
            s2_kind_next  = (rd == 5'd0) ? KIND_JUMP : KIND_CALL;
            writes        = 1'b1;
            s2_imm_next   = imm_j(s1_insn_reg);
            s2_cbase_next = s1_pc_reg;
            s2_cadd_next  = 64'd4;
        end
        else if (opc == OPC_JALR)
        begin
            s2_kind_next  = KIND_JUMP_REG;
            s2_sa_next    = rs1;
            writes        = 1'b1;
            s2_imm_next   = imm_i(s1_insn_reg);
            s2_cbase_next = s1_pc_reg;
            s2_cadd_next  = 64'd4;
        end
        else if (opc == OPC_SYSTEM)
        begin
            // ECALL, and any SYSTEM word with bits 31:20 zero; EBREAK and the rest fall to nop
            if (s1_insn_reg[31:20] == 12'd0)
            begin
                s2_kind_next = KIND_SYSCALL;
                s2_sa_next   = REG_SYSCALL_NUM;
            end
        end

        s2_dst_next = writes ? rd : 5'd0;
        s2_wr_next  = writes && (rd != 5'd0);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_kind_reg  <= s2_kind_next;
            s2_alu_reg   <= s2_alu_next;
            s2_cond_reg  <= s2_cond_next;
            s2_sa_reg    <= s2_sa_next;
            s2_sb_reg    <= s2_sb_next;
            s2_dst_reg   <= s2_dst_next;
            s2_wr_reg    <= s2_wr_next;
            s2_imm_reg   <= s2_imm_next;
            s2_msize_reg <= s2_msize_next;
            s2_msig_reg  <= s2_msig_next;
            s2_cbase_reg <= s2_cbase_next;
            s2_cadd_reg  <= s2_cadd_next;
        end
    end

    assign s3_cval_next = s2_cbase_reg + s2_cadd_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_alu_reg   <= s2_alu_reg;
            s3_cond_reg  <= s2_cond_reg;
            s3_sa_reg    <= s2_sa_reg;
            s3_sb_reg    <= s2_sb_reg;
            s3_dst_reg   <= s2_dst_reg;
            s3_wr_reg    <= s2_wr_reg;
            s3_imm_reg   <= s2_imm_reg;
            s3_cval_reg  <= s3_cval_next;
            s3_msize_reg <= s2_msize_reg;
            s3_msig_reg  <= s2_msig_reg;
        end
    end

    assign done        = s3_valid_reg;
    assign kind        = s3_kind_reg;
    assign alu_op      = s3_alu_reg;
    assign branch_cond = s3_cond_reg;
    assign src_a       = s3_sa_reg;
    assign src_b       = s3_sb_reg;
    assign dest        = s3_dst_reg;
    assign dest_write  = s3_wr_reg;
    assign immediate   = s3_imm_reg;
    assign const_value = s3_cval_reg;
    assign mem_size    = s3_msize_reg;
    assign mem_signed  = s3_msig_reg;

    `RVID_ASSERT_LATER(a_req_to_done, accept, 3, done, "request did not complete in 3 cycles")
    `RVID_ASSERT_SAME(a_dest_nonzero, done && dest_write, dest != 5'd0, "dest_write with dest zero")
    `RVID_ASSERT_SAME(a_alu_none, done && kind != KIND_ALU_REG && kind != KIND_ALU_IMM, alu_op == ALU_NONE, "alu_op set on non-ALU kind")

endmodule
